@@ design/ttc_pkg.sv @@
// Shared constants and types of the text terminal cursor engine.
`timescale 1ns / 1ps

package ttc_pkg;

  // Default geometry
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  // Item field widths
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int NCOL_W = 7;
  localparam int NROW_W = 5;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CELL_W-1:0] CH_SPACE = 16'h0020;

  // Attribute after reset
  localparam logic [CELL_W-1:0] ATTR_RESET = 16'h0F00;

  // APB register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_CELL_ATTR = 1'b0;

  // Cell store port control
  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

@@ design/ttc_if.sv @@
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps

interface ttc_in_if import ttc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [NCOL_W-1:0] new_column;
  logic [NROW_W-1:0] new_row;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, mode, char_code, new_column, new_row, cell_index,
                  input ready);
  modport sink   (input valid, mode, char_code, new_column, new_row, cell_index,
                  output ready);
endinterface

interface ttc_out_if import ttc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;

  modport source (output valid, cursor_position, cell_data, scrolled, input ready);
  modport sink   (input valid, cursor_position, cell_data, scrolled, output ready);
endinterface

@@ design/ttc_cfg_regs.sv @@
// APB register block holding the cell attribute.
`timescale 1ns / 1ps

module ttc_cfg_regs import ttc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CELL_W-1:0] attr
);

  logic [CELL_W-1:0] attr_r;
  logic [CELL_W-1:0] attr_nxt;
  logic              hit;

  // the register is selected by the top address bit alone
  assign hit    = (paddr[APB_AW-1] == REG_CELL_ATTR);
  assign pready = 1'b1;

  always_comb begin
    attr_nxt = attr_r;
    if (psel && penable && pwrite && hit) begin
      attr_nxt = pwdata[CELL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // read back
  assign prdata = hit ? {{(APB_DW-CELL_W){1'b0}}, attr_r} : '0;
  assign attr   = attr_r;

endmodule

@@ design/ttc_cell_ram.sv @@
// Character cell store: one write port, one registered read port.
`timescale 1ns / 1ps

module ttc_cell_ram import ttc_pkg::*; #(
  parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
  parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  logic              clk,
  input  ram_ctl_t          ctl,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/ttc_seq.sv @@
// Request sequencer: cursor logic and the shared sweep counter for fill and scroll.
`timescale 1ns / 1ps

module ttc_seq import ttc_pkg::*; #(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF,
  parameter int ADDR_W   = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  // request side
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [NCOL_W-1:0] in_new_column,
  input  logic [NROW_W-1:0] in_new_row,
  input  logic [IDX_W-1:0]  in_cell_index,
  // attribute
  input  logic [CELL_W-1:0] attr,
  // cell store
  output ram_ctl_t          ram_ctl,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [CELL_W-1:0] ram_rdata,
  // result side
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_cursor_position,
  output logic [CELL_W-1:0] out_cell_data,
  output logic              out_scrolled
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CELLS = COLUMNS * ROWS;

  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOT_A  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [CW-1:0]     LAST_C = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]     LAST_R = RW'(ROWS - 1);

  // sequencer states
  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              cp_we_r, cp_we_nxt;
  logic [ADDR_W-1:0] cp_wa_r, cp_wa_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CHAR_W-1:0] code_r, code_nxt;
  logic [NCOL_W-1:0] ncol_r, ncol_nxt;
  logic [NROW_W-1:0] nrow_r, nrow_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              scr_r, scr_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic [CELL_W-1:0] odata_r, odata_nxt;
  logic              oscr_r, oscr_nxt;

  logic [ADDR_W-1:0] cur_addr;
  logic [CELL_W-1:0] blank;

  // put-character decode
  logic [CW-1:0]     p_col;
  logic [RW-1:0]     p_row;
  logic              p_we;
  logic [ADDR_W-1:0] p_wa;
  logic [CELL_W-1:0] p_wd;
  logic              p_scroll;
  logic              last_row;

  // tab stops per column
  logic              tab_wrap [COLUMNS];
  logic [CW-1:0]     tab_col  [COLUMNS];

  for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
    localparam int NXT = ((g / TAB_STOP) + 1) * TAB_STOP;
    assign tab_wrap[g] = (NXT >= COLUMNS);
    assign tab_col[g]  = CW'(NXT);
  end

  assign cur_addr = ADDR_W'(row_r) * COLS_A + ADDR_W'(col_r);
  assign blank    = attr | CH_SPACE;
  assign last_row = (row_r == LAST_R);

  // cursor update for mode 0
  always_comb begin
    p_col    = col_r;
    p_row    = row_r;
    p_we     = 1'b0;
    p_wa     = cur_addr;
    p_wd     = attr | {{(CELL_W-CHAR_W){1'b0}}, code_r};
    p_scroll = 1'b0;
    case (code_r)
      CH_BS: begin
        p_wd = blank;
        p_wa = cur_addr - ADDR_W'(1);
        if (col_r != '0) begin
          p_col = col_r - CW'(1);
          p_we  = 1'b1;
        end else if (row_r != '0) begin
          p_col = LAST_C;
          p_row = row_r - RW'(1);
          p_we  = 1'b1;
        end
      end
      CH_TAB: begin
        if (tab_wrap[col_r]) begin
          p_col    = '0;
          p_row    = last_row ? row_r : row_r + RW'(1);
          p_scroll = last_row;
        end else begin
          p_col = tab_col[col_r];
        end
      end
      CH_CR: begin
        p_col = '0;
      end
      CH_LF: begin
        p_col    = '0;
        p_row    = last_row ? row_r : row_r + RW'(1);
        p_scroll = last_row;
      end
      default: begin
        p_we = 1'b1;
        if (col_r == LAST_C) begin
          p_col    = '0;
          p_row    = last_row ? row_r : row_r + RW'(1);
          p_scroll = last_row;
        end else begin
          p_col = col_r + CW'(1);
        end
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cp_we_nxt     = 1'b0;
    cp_wa_nxt     = cp_wa_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mode_nxt      = mode_r;
    code_nxt      = code_r;
    ncol_nxt      = ncol_r;
    nrow_nxt      = nrow_r;
    idx_nxt       = idx_r;
    scr_nxt       = scr_r;
    data_nxt      = data_r;
    opos_nxt      = opos_r;
    odata_nxt     = odata_r;
    oscr_nxt      = oscr_r;
    ram_ctl       = '0;
    ram_waddr     = cp_wa_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = cnt_r;

    // pending scroll copy write
    if (cp_we_r) begin
      ram_ctl.we = 1'b1;
    end

    case (state_r)
      S_INIT: begin
        ram_ctl.we = 1'b1;
        ram_waddr  = cnt_r;
        ram_wdata  = ATTR_RESET | CH_SPACE;
        if (cnt_r == LAST_A) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          code_nxt  = in_char_code;
          ncol_nxt  = in_new_column;
          nrow_nxt  = in_new_row;
          idx_nxt   = in_cell_index;
          scr_nxt   = 1'b0;
          data_nxt  = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_r)
          MODE_PUT: begin
            col_nxt    = p_col;
            row_nxt    = p_row;
            ram_ctl.we = p_we;
            ram_waddr  = p_wa;
            ram_wdata  = p_wd;
            if (p_scroll) begin
              scr_nxt   = 1'b1;
              cnt_nxt   = COLS_A;
              state_nxt = S_COPY;
            end else begin
              state_nxt = S_DONE;
            end
          end
          MODE_MOVE: begin
            col_nxt = (32'(ncol_r) > 32'(COLUMNS - 1)) ? LAST_C : CW'(ncol_r);
            row_nxt = (32'(nrow_r) > 32'(ROWS - 1)) ? LAST_R : RW'(nrow_r);
            state_nxt = S_DONE;
          end
          MODE_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_FILL;
          end
          default: begin
            if (32'(idx_r) < 32'(CELLS)) begin
              ram_ctl.re = 1'b1;
              ram_raddr  = ADDR_W'(idx_r);
              state_nxt  = S_RDWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end
      S_COPY: begin
        // read one row ahead, write it back in the next cycle
        ram_ctl.re = 1'b1;
        ram_raddr  = cnt_r;
        cp_we_nxt  = 1'b1;
        cp_wa_nxt  = cnt_r - COLS_A;
        if (cnt_r == LAST_A) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        cnt_nxt   = BOT_A;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        ram_ctl.we = 1'b1;
        ram_waddr  = cnt_r;
        ram_wdata  = blank;
        if (cnt_r == LAST_A) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_RDWAIT: begin
        data_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      default: begin
        // S_DONE: hand the result to the output register
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          opos_nxt      = POS_W'(cur_addr);
          odata_nxt     = data_r;
          oscr_nxt      = scr_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      cp_we_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cp_we_r     <= cp_we_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cp_wa_r <= cp_wa_nxt;
    mode_r  <= mode_nxt;
    code_r  <= code_nxt;
    ncol_r  <= ncol_nxt;
    nrow_r  <= nrow_nxt;
    idx_r   <= idx_nxt;
    scr_r   <= scr_nxt;
    data_r  <= data_nxt;
    opos_r  <= opos_nxt;
    odata_r <= odata_nxt;
    oscr_r  <= oscr_nxt;
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_cursor_position = opos_r;
  assign out_cell_data       = odata_r;
  assign out_scrolled        = oscr_r;

endmodule

@@ design/text_terminal_cursor_engine_top.sv @@
// Top level of the text terminal cursor engine.
`timescale 1ns / 1ps
//
// Character-cell terminal with a COLUMNS x ROWS store of 16-bit cells.
// in_ch carries one request item (put byte, move cursor, clear, read cell);
// out_ch returns exactly one result item for each request: cursor position,
// cell data for reads, and a scrolled flag. APB writes set the attribute.
// Scroll copies the rows up and blanks the bottom row; clear blanks every
// cell. Both go one cell a cycle through the single store port pair.
// After reset a blanking pass writes every cell once; in_ch.ready stays low
// meanwhile, APB writes still work.
// The result sits in an output register, so the next request is taken while
// it waits; a further result holds until out_ch.ready takes the first one.
//
module text_terminal_cursor_engine_top import ttc_pkg::*; #(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ttc_in_if.sink            in_ch,
  ttc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [CELL_W-1:0] attr;
  ram_ctl_t          ram_ctl;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // attribute register
  ttc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  // cell store
  ttc_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  ttc_seq #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .ADDR_W   (ADDR_W)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_mode             (in_ch.mode),
    .in_char_code        (in_ch.char_code),
    .in_new_column       (in_ch.new_column),
    .in_new_row          (in_ch.new_row),
    .in_cell_index       (in_ch.cell_index),
    .attr                (attr),
    .ram_ctl             (ram_ctl),
    .ram_waddr           (ram_waddr),
    .ram_wdata           (ram_wdata),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_cursor_position (out_ch.cursor_position),
    .out_cell_data       (out_ch.cell_data),
    .out_scrolled        (out_ch.scrolled)
  );

endmodule
